// ===== rtl/skts_pkg.sv =====
// ----------------------------------------------------------------------------
// skts_pkg
// Shared types and constants for the sorted key table search block.
// ----------------------------------------------------------------------------
package skts_pkg;

	localparam int TABLE_DEPTH_DEF = 128;
	localparam int KEY_W           = 31;
	localparam int PAY_W           = 31;
	localparam int STATUS_W        = 3;
	localparam int HELD_W          = 8;

	typedef enum logic {
		OP_INSERT = 1'b0,
		OP_SEARCH = 1'b1
	} opcode_t;

	typedef enum logic [STATUS_W-1:0] {
		ST_INSERTED  = 3'd0,
		ST_DUPLICATE = 3'd1,
		ST_FULL      = 3'd2,
		ST_FOUND     = 3'd3,
		ST_MISSING   = 3'd4
	} status_t;

	// contents of one table cell
	typedef struct packed {
		logic             valid;
		logic [KEY_W-1:0] key;
		logic [PAY_W-1:0] payload;
	} cell_t;

	// broadcast from the controller to every cell
	typedef struct packed {
		logic             ins_en;
		logic [KEY_W-1:0] key;
		logic [PAY_W-1:0] payload;
	} cell_cmd_t;

	// compare results a cell reports
	typedef struct packed {
		logic lt;
		logic eq;
	} cell_flags_t;

endpackage

// ===== rtl/skts_req_if.sv =====
// ----------------------------------------------------------------------------
// skts_req_if
// Request channel: valid/ready with opcode, key and payload.
// ----------------------------------------------------------------------------
interface skts_req_if;
	logic                      valid;
	logic                      ready;
	logic                      opcode;
	logic [skts_pkg::KEY_W-1:0] key;
	logic [skts_pkg::PAY_W-1:0] payload;

	modport source (output valid, output opcode, output key, output payload, input ready);
	modport sink   (input valid, input opcode, input key, input payload, output ready);
endinterface

// ===== rtl/skts_rsp_if.sv =====
// ----------------------------------------------------------------------------
// skts_rsp_if
// Response channel: valid/ready with status, empty flag, payload and count.
// ----------------------------------------------------------------------------
interface skts_rsp_if;
	logic                         valid;
	logic                         ready;
	logic [skts_pkg::STATUS_W-1:0] status;
	logic                         empty_flag;
	logic [skts_pkg::PAY_W-1:0]    found_payload;
	logic [skts_pkg::HELD_W-1:0]   entries_held;

	modport source (output valid, output status, output empty_flag, output found_payload,
		output entries_held, input ready);
	modport sink   (input valid, input status, input empty_flag, input found_payload,
		input entries_held, output ready);
endinterface

// ===== rtl/skts_cell.sv =====
// ----------------------------------------------------------------------------
// skts_cell
// One slot of the sorted table. Compares its key with the broadcast key and,
// on insert, either keeps its record, takes the new one, or takes its lower
// neighbor's record (shift up by one).
// ----------------------------------------------------------------------------
module skts_cell (
	input  logic                  clk,
	input  logic                  arst_n,
	input  skts_pkg::cell_cmd_t   cmd,
	input  skts_pkg::cell_t       prev,
	input  logic                  prev_lt,
	output skts_pkg::cell_t       cur,
	output skts_pkg::cell_flags_t flags
);

	logic                       valid_q;
	logic [skts_pkg::KEY_W-1:0] key_q;
	logic [skts_pkg::PAY_W-1:0] payload_q;
	logic                       move;

	assign flags.lt = valid_q && (key_q < cmd.key);
	assign flags.eq = valid_q && (key_q == cmd.key);
	assign move     = cmd.ins_en && !flags.lt;
	assign cur      = '{valid: valid_q, key: key_q, payload: payload_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (move) begin
			valid_q <= prev_lt ? 1'b1 : prev.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (move) begin
			if (prev_lt) begin
				key_q     <= cmd.key;
				payload_q <= cmd.payload;
			end else begin
				key_q     <= prev.key;
				payload_q <= prev.payload;
			end
		end
	end

endmodule

// ===== rtl/sorted_key_table_search.sv =====
// ----------------------------------------------------------------------------
// sorted_key_table_search
// Keyed record table held in ascending key order in a row of cells.
// ----------------------------------------------------------------------------
// Each item is captured from the request transfer in S_IDLE, then in S_EXEC
// every cell compares its key with the broadcast key and, on a successful
// insert, the cells above the insertion point shift up by one. The result is
// loaded into an output register in S_EXEC; the next request is taken in the
// following cycle. If the previous result has not yet been taken, S_EXEC
// repeats until the output register frees up.
// ----------------------------------------------------------------------------
module sorted_key_table_search #(
	parameter int TABLE_DEPTH = skts_pkg::TABLE_DEPTH_DEF
) (
	input logic           clk,
	input logic           arst_n,
	skts_req_if.sink      req,
	skts_rsp_if.source    rsp
);

	localparam int CW = $clog2(TABLE_DEPTH + 1);

	typedef enum logic {
		S_IDLE,
		S_EXEC
	} state_t;

	state_t                      state_q;
	logic                        opcode_q;
	logic [skts_pkg::KEY_W-1:0]  key_q;
	logic [skts_pkg::PAY_W-1:0]  payload_q;
	logic [CW-1:0]               count_q;
	logic                        rsp_valid_q;
	skts_pkg::status_t           status_q;
	logic                        empty_q;
	logic [skts_pkg::PAY_W-1:0]  found_q;
	logic [skts_pkg::HELD_W-1:0] held_q;

	skts_pkg::cell_cmd_t         cmd;
	skts_pkg::cell_t             cells [TABLE_DEPTH];
	skts_pkg::cell_flags_t       flags [TABLE_DEPTH];
	logic [TABLE_DEPTH-1:0]      valid_vec;

	logic                        hit;
	logic [skts_pkg::PAY_W-1:0]  hit_payload;
	logic                        full;
	logic                        advance;
	logic                        ins_ok;
	skts_pkg::status_t           status_d;
	logic                        empty_d;
	logic [skts_pkg::PAY_W-1:0]  found_d;
	logic [CW-1:0]               count_d;

	assign req.ready         = (state_q == S_IDLE);
	assign rsp.valid         = rsp_valid_q;
	assign rsp.status        = status_q;
	assign rsp.empty_flag    = empty_q;
	assign rsp.found_payload = found_q;
	assign rsp.entries_held  = held_q;

	assign full    = (count_q == CW'(TABLE_DEPTH));
	assign advance = (state_q == S_EXEC) && (!rsp_valid_q || rsp.ready);
	assign ins_ok  = (opcode_q == skts_pkg::OP_INSERT) && !full && !hit;

	assign cmd.ins_en  = advance && ins_ok;
	assign cmd.key     = key_q;
	assign cmd.payload = payload_q;

	for (genvar g = 0; g < TABLE_DEPTH; g++) begin : g_cell
		skts_pkg::cell_t prev;
		logic            prev_lt;
		if (g == 0) begin : g_first
			assign prev    = '0;
			assign prev_lt = 1'b1;
		end else begin : g_rest
			assign prev    = cells[g-1];
			assign prev_lt = flags[g-1].lt;
		end
		skts_cell u_cell (
			.clk     (clk),
			.arst_n  (arst_n),
			.cmd     (cmd),
			.prev    (prev),
			.prev_lt (prev_lt),
			.cur     (cells[g]),
			.flags   (flags[g])
		);
	end

	// keys are unique, so at most one cell matches
	always_comb begin
		hit         = 1'b0;
		hit_payload = '0;
		for (int i = 0; i < TABLE_DEPTH; i++) begin
			hit          = hit | flags[i].eq;
			hit_payload  = hit_payload | ({skts_pkg::PAY_W{flags[i].eq}} & cells[i].payload);
			valid_vec[i] = cells[i].valid;
		end
	end

	always_comb begin
		status_d = skts_pkg::ST_MISSING;
		empty_d  = 1'b0;
		found_d  = '0;
		count_d  = count_q;
		if (opcode_q == skts_pkg::OP_INSERT) begin
			priority if (full) begin
				status_d = skts_pkg::ST_FULL;
			end else if (hit) begin
				status_d = skts_pkg::ST_DUPLICATE;
			end else begin
				status_d = skts_pkg::ST_INSERTED;
				count_d  = count_q + 1'b1;
			end
		end else begin
			priority if (count_q == '0) begin
				status_d = skts_pkg::ST_MISSING;
				empty_d  = 1'b1;
			end else if (hit) begin
				status_d = skts_pkg::ST_FOUND;
				found_d  = hit_payload;
			end else begin
				status_d = skts_pkg::ST_MISSING;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			opcode_q    <= 1'b0;
			key_q       <= '0;
			payload_q   <= '0;
			count_q     <= '0;
			rsp_valid_q <= 1'b0;
			status_q    <= skts_pkg::ST_INSERTED;
			empty_q     <= 1'b0;
			found_q     <= '0;
			held_q      <= '0;
		end else begin
			if (advance) begin
				rsp_valid_q <= 1'b1;
			end else if (rsp.ready) begin
				rsp_valid_q <= 1'b0;
			end
			unique case (state_q)
				S_IDLE: begin
					if (req.valid) begin
						opcode_q  <= req.opcode;
						key_q     <= req.key;
						payload_q <= req.payload;
						state_q   <= S_EXEC;
					end
				end
				S_EXEC: begin
					if (advance) begin
						status_q    <= status_d;
						empty_q     <= empty_d;
						found_q     <= found_d;
						held_q      <= skts_pkg::HELD_W'(count_d);
						count_q     <= count_d;
						state_q     <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CW'(TABLE_DEPTH))
		else $error("record count beyond table depth");

	a_valid_matches_count: assert property (@(posedge clk) disable iff (!arst_n)
		$countones(valid_vec) == int'(count_q))
		else $error("occupied cells disagree with record count");

	a_insert_counts: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.ins_en |=> count_q == $past(count_q) + 1'b1)
		else $error("insert did not advance record count");

	a_rsp_from_exec: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(rsp_valid_q) |-> $past(state_q == S_EXEC))
		else $error("result raised outside execute cycle");

	a_no_insert_when_full: assert property (@(posedge clk) disable iff (!arst_n)
		full |-> !cmd.ins_en)
		else $error("insert into full table");

endmodule

// ===== verif/tb_top.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for sorted_key_table_search. A queue of insert and
// search requests is streamed through the request channel with random gaps.
// Every request transfer is run through a local model of the sorted table,
// and each response transfer is compared against the oldest predicted result.
// The response side stalls at random and once holds off long enough to back
// up the block. Coverage runs from an empty table through a full one.
// ----------------------------------------------------------------------------
module tb_top;

	localparam int DEPTH        = skts_pkg::TABLE_DEPTH_DEF;
	localparam int KEY_W        = skts_pkg::KEY_W;
	localparam int PAY_W        = skts_pkg::PAY_W;
	localparam int HELD_W       = skts_pkg::HELD_W;
	localparam int RAND_ITEMS   = 1880;
	localparam int TAIL_ITEMS   = 150;
	localparam int HOLD_START   = 1500;
	localparam int HOLD_LEN     = 160;
	localparam int DRAIN_CYCLES = 12;

	typedef struct {
		skts_pkg::opcode_t op;
		logic [KEY_W-1:0]  key;
		logic [PAY_W-1:0]  payload;
	} table_req_t;

	typedef struct {
		skts_pkg::status_t status;
		logic              empty_flag;
		logic [PAY_W-1:0]  found_payload;
		logic [HELD_W-1:0] entries_held;
	} table_rsp_t;

	logic clk = 1'b0;
	logic arst_n;

	skts_req_if req_ch();
	skts_rsp_if rsp_ch();

	sorted_key_table_search #(.TABLE_DEPTH(DEPTH)) u_dut (
		.clk   (clk),
		.arst_n(arst_n),
		.req   (req_ch),
		.rsp   (rsp_ch)
	);

	always #6 clk = ~clk;

	table_req_t request_q[$];
	table_rsp_t expected_rsp_q[$];
	logic [KEY_W-1:0] offered_keys[$];

	logic [KEY_W-1:0] tbl_keys[DEPTH];
	logic [PAY_W-1:0] tbl_pays[DEPTH];
	int tbl_count = 0;

	int n_items = 0;
	int accepted_cnt = 0;
	int checked_cnt = 0;
	int fail_cnt = 0;
	int src_gap = 0;
	int sink_gap = 0;
	int cyc_cnt;
	int hold_left;

	// Fibonacci search over the held keys; returns the index or -1
	function automatic int fib_lookup(logic [KEY_W-1:0] k);
		int n, fa, fb, fc, base, p;
		n    = tbl_count;
		fa   = 0;
		fb   = 1;
		fc   = 1;
		base = -1;
		while (fc < n) begin
			fa = fb;
			fb = fc;
			fc = fa + fb;
		end
		while (fc > 1) begin
			p = base + fa;
			if (p > n - 1) p = n - 1;
			if (p < 0) p = 0;
			if (tbl_keys[p] < k) begin
				fc   = fb;
				fb   = fa;
				fa   = fc - fb;
				base = p;
			end else if (tbl_keys[p] > k) begin
				fc = fa;
				fb = fb - fa;
				fa = fc - fb;
			end else begin
				return p;
			end
		end
		// last probe only while it stays inside the held records
		if (fb != 0 && base + 1 >= 0 && base + 1 < n && tbl_keys[base + 1] == k)
			return base + 1;
		return -1;
	endfunction

	function automatic table_rsp_t apply_table_op(logic op, logic [KEY_W-1:0] k,
		logic [PAY_W-1:0] pay);
		table_rsp_t r;
		int pos, hit;
		r.status        = skts_pkg::ST_MISSING;
		r.empty_flag    = 1'b0;
		r.found_payload = '0;
		if (skts_pkg::opcode_t'(op) == skts_pkg::OP_INSERT) begin
			if (tbl_count >= DEPTH) begin
				r.status = skts_pkg::ST_FULL;
			end else begin
				pos = 0;
				while (pos < tbl_count && tbl_keys[pos] < k) pos++;
				if (pos < tbl_count && tbl_keys[pos] == k) begin
					r.status = skts_pkg::ST_DUPLICATE;
				end else begin
					for (int j = tbl_count; j > pos; j--) begin
						tbl_keys[j] = tbl_keys[j - 1];
						tbl_pays[j] = tbl_pays[j - 1];
					end
					tbl_keys[pos] = k;
					tbl_pays[pos] = pay;
					tbl_count++;
					r.status = skts_pkg::ST_INSERTED;
				end
			end
		end else if (tbl_count == 0) begin
			r.empty_flag = 1'b1;
		end else begin
			hit = fib_lookup(k);
			if (hit >= 0) begin
				r.status        = skts_pkg::ST_FOUND;
				r.found_payload = tbl_pays[hit];
			end
		end
		r.entries_held = HELD_W'(tbl_count);
		return r;
	endfunction

	task automatic add_req(skts_pkg::opcode_t op, logic [KEY_W-1:0] k,
		logic [PAY_W-1:0] pay);
		table_req_t t;
		t.op      = op;
		t.key     = k;
		t.payload = pay;
		request_q.push_back(t);
		if (op == skts_pkg::OP_INSERT) offered_keys.push_back(k);
	endtask

	function automatic logic [KEY_W-1:0] pick_offered();
		if (offered_keys.size() == 0) return KEY_W'($urandom());
		return offered_keys[$urandom_range(0, offered_keys.size() - 1)];
	endfunction

	// request driver
	always @(posedge clk or negedge arst_n) begin
		table_req_t nxt;
		if (!arst_n) begin
			req_ch.valid   <= 1'b0;
			req_ch.opcode  <= skts_pkg::OP_INSERT;
			req_ch.key     <= '0;
			req_ch.payload <= '0;
			src_gap = 0;
		end else begin
			if (req_ch.valid && req_ch.ready) begin
				expected_rsp_q.push_back(apply_table_op(req_ch.opcode, req_ch.key,
					req_ch.payload));
				accepted_cnt++;
			end
			if (!req_ch.valid || req_ch.ready) begin
				if (src_gap > 0) begin
					src_gap--;
					req_ch.valid <= 1'b0;
				end else if (request_q.size() > 0) begin
					nxt = request_q.pop_front();
					req_ch.valid   <= 1'b1;
					req_ch.opcode  <= nxt.op;
					req_ch.key     <= nxt.key;
					req_ch.payload <= nxt.payload;
					if (n_items - accepted_cnt > TAIL_ITEMS && $urandom_range(0, 7) == 0)
						src_gap = $urandom_range(1, 13);
				end else begin
					req_ch.valid <= 1'b0;
				end
			end
		end
	end

	// long receiver hold-off so the block backs up and stalls its input
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cyc_cnt   <= 0;
			hold_left <= 0;
		end else begin
			cyc_cnt <= cyc_cnt + 1;
			if (cyc_cnt == HOLD_START)
				hold_left <= HOLD_LEN;
			else if (hold_left != 0)
				hold_left <= hold_left - 1;
		end
	end

	// response monitor
	always @(posedge clk or negedge arst_n) begin
		table_rsp_t exp_rsp;
		if (!arst_n) begin
			rsp_ch.ready <= 1'b0;
			sink_gap = 0;
		end else begin
			if (rsp_ch.valid && rsp_ch.ready) begin
				checked_cnt++;
				if (expected_rsp_q.size() == 0) begin
					$error("response transfer with no pending request");
					fail_cnt++;
				end else begin
					exp_rsp = expected_rsp_q.pop_front();
					if (rsp_ch.status !== exp_rsp.status) begin
						$error("status: expected %0d, actual %0d", exp_rsp.status,
							rsp_ch.status);
						fail_cnt++;
					end
					if (rsp_ch.empty_flag !== exp_rsp.empty_flag) begin
						$error("empty_flag: expected %0d, actual %0d", exp_rsp.empty_flag,
							rsp_ch.empty_flag);
						fail_cnt++;
					end
					if (rsp_ch.found_payload !== exp_rsp.found_payload) begin
						$error("found_payload: expected %0h, actual %0h",
							exp_rsp.found_payload, rsp_ch.found_payload);
						fail_cnt++;
					end
					if (rsp_ch.entries_held !== exp_rsp.entries_held) begin
						$error("entries_held: expected %0d, actual %0d",
							exp_rsp.entries_held, rsp_ch.entries_held);
						fail_cnt++;
					end
				end
			end
			if (hold_left != 0) begin
				rsp_ch.ready <= 1'b0;
			end else if (sink_gap > 0) begin
				sink_gap--;
				rsp_ch.ready <= 1'b0;
			end else begin
				rsp_ch.ready <= 1'b1;
				if (n_items - checked_cnt > TAIL_ITEMS && $urandom_range(0, 9) == 0)
					sink_gap = $urandom_range(1, 13);
			end
		end
	end

	initial begin
		logic [KEY_W-1:0] k;
		int sel;
		arst_n = 1'b0;

		// empty table, key zero, extremes, duplicates, hits and misses
		add_req(skts_pkg::OP_SEARCH, 31'd5, 31'h7FFF_FFFF);
		add_req(skts_pkg::OP_SEARCH, 31'h7FFF_FFFF, 31'd0);
		add_req(skts_pkg::OP_INSERT, 31'd0, 31'h7FFF_FFFF);
		add_req(skts_pkg::OP_SEARCH, 31'd0, 31'd0);
		add_req(skts_pkg::OP_INSERT, 31'h7FFF_FFFF, 31'd0);
		add_req(skts_pkg::OP_INSERT, 31'd1, 31'd1);
		add_req(skts_pkg::OP_INSERT, 31'd0, 31'h1234_5678);
		add_req(skts_pkg::OP_INSERT, 31'h7FFF_FFFF, 31'h7FFF_FFFF);
		add_req(skts_pkg::OP_SEARCH, 31'h7FFF_FFFF, 31'h7FFF_FFFF);
		add_req(skts_pkg::OP_SEARCH, 31'd1, 31'd0);
		add_req(skts_pkg::OP_SEARCH, 31'd2, 31'd0);
		add_req(skts_pkg::OP_SEARCH, 31'h7FFF_FFFE, 31'd0);
		add_req(skts_pkg::OP_INSERT, 31'h5555_5555, 31'h2AAA_AAAA);
		add_req(skts_pkg::OP_INSERT, 31'h2AAA_AAAA, 31'h5555_5555);
		add_req(skts_pkg::OP_SEARCH, 31'h5555_5555, 31'd0);
		add_req(skts_pkg::OP_SEARCH, 31'h2AAA_AAAA, 31'd0);
		add_req(skts_pkg::OP_SEARCH, 31'h4000_0000, 31'd0);
		add_req(skts_pkg::OP_INSERT, 31'h4000_0000, 31'h0000_0001);
		add_req(skts_pkg::OP_SEARCH, 31'h4000_0000, 31'd0);
		add_req(skts_pkg::OP_SEARCH, 31'h3FFF_FFFF, 31'd0);

		// random mix; the table fills part way through, then stays full
		for (int i = 0; i < RAND_ITEMS; i++) begin
			sel = $urandom_range(0, 99);
			if (sel < 40) begin
				sel = $urandom_range(0, 99);
				if (sel < 72) k = KEY_W'($urandom());
				else if (sel < 88) k = pick_offered();
				else k = KEY_W'($urandom_range(1, 300));
				add_req(skts_pkg::OP_INSERT, k, PAY_W'($urandom()));
			end else begin
				sel = $urandom_range(0, 99);
				if (sel < 50) k = pick_offered();
				else if (sel < 62) k = pick_offered() + 1'b1;
				else if (sel < 74) k = pick_offered() - 1'b1;
				else k = KEY_W'($urandom());
				add_req(skts_pkg::OP_SEARCH, k, PAY_W'($urandom()));
			end
		end
		n_items = request_q.size();

		repeat (5) @(posedge clk);
		@(negedge clk) arst_n = 1'b1;

		while (accepted_cnt < n_items || expected_rsp_q.size() != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);

		if (fail_cnt == 0)
			$display("== PASS ==");
		else
			$display("== FAIL ==");
		$finish;
	end

	initial begin
		#5_000_000;
		$display("== FAIL ==");
		$finish;
	end

endmodule
